// ----- rtl/plb_pkg.sv -----
// Shared types and constants for the positional list buffer.
// Used by plb_ctrl, plb_dpath, the top level and the port checker.
package plb_pkg;

    // Storage geometry
    localparam int CAPACITY   = 16;
    localparam int WORD_WIDTH = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // Field widths of the request and response beats
    localparam int TYPE_W = 3;
    localparam int POS_W  = 5;
    localparam int STAT_W = 3;
    localparam int FPOS_W = 4;

    // Request codes
    localparam logic [TYPE_W-1:0] REQ_INSERT = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_REMOVE = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_FIND   = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_READ   = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_FIRST  = 3'd4;
    localparam logic [TYPE_W-1:0] REQ_LAST   = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

    // Request beat
    typedef struct packed {
        logic [TYPE_W-1:0]     req_type;
        logic [POS_W-1:0]      position;
        logic [WORD_WIDTH-1:0] item_word;
    } t_req;

    // Response beat
    typedef struct packed {
        logic [STAT_W-1:0]     status;
        logic [WORD_WIDTH-1:0] result_word;
        logic [FPOS_W-1:0]     found_position;
        logic [CNT_W-1:0]      item_count;
    } t_rsp;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;    // latch the request beat, clear the scan index
        logic execute;    // run a non-find request and post its response
        logic scan_step;  // advance the find index
        logic scan_done;  // post the find response
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_find;
        logic scan_hit;
        logic scan_end;
    } t_stat;

endpackage

// ----- rtl/positional_list_buffer.sv -----
// Top level of the positional list buffer: sequencer plus datapath.
// Depends on plb_pkg, plb_ctrl and plb_dpath.
// Sequence: the accept edge captures the request, then the execute state registers the
// response that o_done shows; find instead scans until the match position or the count.
// Throughput: one request at a time; the next start is taken in the o_done cycle.
// Find walks the cells one per cycle through the single read port.
// Reset: synchronous active-low; count clears, cell contents stay unknown until written.
// The receiver cannot stall: each response is shown for exactly one cycle.
module positional_list_buffer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  plb_pkg::t_req  i_req,
    output logic           o_done,
    output plb_pkg::t_rsp  o_rsp
);

    plb_pkg::t_cmd  cmd;
    plb_pkg::t_stat stat;

    // Sequencer
    plb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Cells, count and response register
    plb_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

endmodule

// ----- rtl/plb_ctrl.sv -----
// Request sequencer for the positional list buffer.
// Depends on plb_pkg for the command and status structs.
module plb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  plb_pkg::t_stat  i_stat,
    output plb_pkg::t_cmd   o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.is_find) begin
                    n_state = S_SCAN;
                end else begin
                    o_cmd.execute = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_SCAN: begin
                // end of list or a hit ends the scan; the datapath ranks end of list first: the hit flag is stale there
                if (i_stat.scan_end || i_stat.scan_hit) begin
                    o_cmd.scan_done = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_busy = (n_state != S_IDLE);
    end

    // State and registered busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign busy = r_busy;

endmodule

// ----- rtl/plb_dpath.sv -----
// Datapath of the positional list buffer: entry cells, count, scan index
// and response register. Depends on plb_pkg.
module plb_dpath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  plb_pkg::t_req   i_req,
    input  plb_pkg::t_cmd   i_cmd,
    output plb_pkg::t_stat  o_stat,
    output logic            o_done,
    output plb_pkg::t_rsp   o_rsp
);

    plb_pkg::t_req r_req;
    logic [plb_pkg::CNT_W-1:0]      r_idx;
    logic [plb_pkg::CNT_W-1:0]      r_count, n_count;
    logic [plb_pkg::WORD_WIDTH-1:0] r_cells [plb_pkg::CAPACITY];
    logic [plb_pkg::WORD_WIDTH-1:0] n_cells [plb_pkg::CAPACITY];
    logic                           r_done;
    plb_pkg::t_rsp                  r_rsp;

    logic [plb_pkg::CNT_W-1:0]      cnt_m1;
    logic [plb_pkg::ADDR_W-1:0]     rd_addr;
    logic [plb_pkg::WORD_WIDTH-1:0] rd_word;
    logic [plb_pkg::STAT_W-1:0]     ex_status;
    logic [plb_pkg::WORD_WIDTH-1:0] ex_word;
    logic                           do_ins;
    logic                           do_rem;

    assign cnt_m1 = r_count - 1'b1;

    // Single read port into the cells
    always_comb begin
        case (r_req.req_type)
            plb_pkg::REQ_FIND:  rd_addr = r_idx[plb_pkg::ADDR_W-1:0];
            plb_pkg::REQ_FIRST: rd_addr = '0;
            plb_pkg::REQ_LAST:  rd_addr = cnt_m1[plb_pkg::ADDR_W-1:0];
            default:            rd_addr = r_req.position[plb_pkg::ADDR_W-1:0];
        endcase
    end
    assign rd_word = r_cells[rd_addr];

    // Status toward the controller
    assign o_stat.is_find  = (r_req.req_type == plb_pkg::REQ_FIND);
    assign o_stat.scan_hit = (rd_word == r_req.item_word);
    assign o_stat.scan_end = (r_idx >= r_count);

    // Decode of the non-find requests
    always_comb begin
        ex_status = plb_pkg::ST_OK;
        ex_word   = '0;
        do_ins    = 1'b0;
        do_rem    = 1'b0;
        case (r_req.req_type)
            plb_pkg::REQ_INSERT: begin
                if (r_req.position > r_count) begin
                    ex_status = plb_pkg::ST_BADPOS;
                end else if (r_count >= plb_pkg::CNT_W'(plb_pkg::CAPACITY)) begin
                    ex_status = plb_pkg::ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            plb_pkg::REQ_REMOVE: begin
                if (r_count == '0) begin
                    ex_status = plb_pkg::ST_EMPTY;
                end else if (r_req.position >= r_count) begin
                    ex_status = plb_pkg::ST_BADPOS;
                end else begin
                    ex_word = rd_word;
                    do_rem  = 1'b1;
                end
            end
            plb_pkg::REQ_READ: begin
                if (r_req.position >= r_count) begin
                    ex_status = plb_pkg::ST_BADPOS;
                end else begin
                    ex_word = rd_word;
                end
            end
            plb_pkg::REQ_FIRST, plb_pkg::REQ_LAST: begin
                if (r_count == '0) begin
                    ex_status = plb_pkg::ST_EMPTY;
                end else begin
                    ex_word = rd_word;
                end
            end
            default: begin
                ex_status = plb_pkg::ST_BADPOS;
            end
        endcase
    end

    // Per-cell shift: insert pulls from below, remove pulls from above
    always_comb begin
        for (int i = 0; i < plb_pkg::CAPACITY; i++) begin
            logic [plb_pkg::CNT_W-1:0] ci;
            ci         = plb_pkg::CNT_W'(i);
            n_cells[i] = r_cells[i];
            if (do_ins) begin
                if (ci == r_req.position) begin
                    n_cells[i] = r_req.item_word;
                end else if (ci > r_req.position) begin
                    n_cells[i] = r_cells[(i == 0) ? 0 : i - 1];
                end
            end else if (do_rem) begin
                if (ci == cnt_m1) begin
                    n_cells[i] = '0;
                end else if (ci >= r_req.position && ci < cnt_m1) begin
                    n_cells[i] = r_cells[(i == plb_pkg::CAPACITY - 1) ? i : i + 1];
                end
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (do_ins) begin
            n_count = r_count + 1'b1;
        end else if (do_rem) begin
            n_count = cnt_m1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            if (i_cmd.execute) begin
                r_count <= n_count;
            end
            r_done <= i_cmd.execute | i_cmd.scan_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
            r_idx <= '0;
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.execute) begin
            for (int i = 0; i < plb_pkg::CAPACITY; i++) begin
                r_cells[i] <= n_cells[i];
            end
            r_rsp.status         <= ex_status;
            r_rsp.result_word    <= ex_word;
            r_rsp.found_position <= '0;
            r_rsp.item_count     <= n_count;
        end else if (i_cmd.scan_done) begin
            r_rsp.status         <= o_stat.scan_end ? plb_pkg::ST_NOTFOUND : plb_pkg::ST_OK;
            r_rsp.result_word    <= '0;
            r_rsp.found_position <= o_stat.scan_end ? '0 : r_idx[plb_pkg::FPOS_W-1:0];
            r_rsp.item_count     <= r_count;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// ----- rtl/plb_checker.sv -----
// Port-level checks for the positional list buffer, bound to the top level.
// Depends on plb_pkg.
module plb_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input plb_pkg::t_req  i_req,
    input logic           o_done,
    input plb_pkg::t_rsp  o_rsp
);

    // An accepted beat makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted request");

    // A response only follows a busy cycle and ends it
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(busy) && !busy))
        else $error("response strobe without a preceding busy cycle");

    // Count never exceeds capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rsp.item_count <= plb_pkg::CNT_W'(plb_pkg::CAPACITY)))
        else $error("item count above capacity");

    // Failed requests carry no word and no position
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status != plb_pkg::ST_OK) |->
        (o_rsp.result_word == '0 && o_rsp.found_position == '0))
        else $error("failed request returned data");

    // Count changes by at most one between responses that follow each other with no idle gap
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(o_done, 2)) |->
        (o_rsp.item_count == $past(o_rsp.item_count) ||
         o_rsp.item_count == $past(o_rsp.item_count) + 1'b1 ||
         o_rsp.item_count == $past(o_rsp.item_count) - 1'b1))
        else $error("item count jumped by more than one");

endmodule

bind positional_list_buffer plb_checker u_plb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_req   (i_req),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);

// ----- test/positional_list_buffer_tb.sv -----
// Self-checking testbench for positional_list_buffer: directed and random requests,
// each response predicted by a behavioral copy of the list and checked field by field.
// Depends on plb_pkg and the positional_list_buffer RTL.
module positional_list_buffer_tb;
    import plb_pkg::*;

    // Request codes the block does not define; they must report a bad position
    localparam logic [TYPE_W-1:0] REQ_RSVD_6 = 3'd6;
    localparam logic [TYPE_W-1:0] REQ_RSVD_7 = 3'd7;

    localparam int STALL_LIMIT   = 1000;
    localparam int DRAIN_CYCLES  = 25;
    localparam int REPORT_LIMIT  = 10;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_req  i_req;
    logic  o_done;
    t_rsp  o_rsp;

    // Shadow copy of the list contents and length
    logic [WORD_WIDTH-1:0] list_words [CAPACITY];
    int                    list_len;

    t_rsp rsp_expected_q[$];
    int   fail_count;
    int   stall_cycles;
    bit   gaps_on;

    positional_list_buffer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one request to the shadow list and return the response it produces
    function automatic t_rsp apply_list_op(t_req r);
        t_rsp rsp;
        bit   hit;
        int   i;
        rsp = '0;
        rsp.status = ST_OK;
        hit = 1'b0;
        case (r.req_type)
            REQ_INSERT: begin
                if (r.position > list_len) begin
                    rsp.status = ST_BADPOS;
                end else if (list_len >= CAPACITY) begin
                    rsp.status = ST_FULL;
                end else begin
                    for (i = list_len; i > r.position; i--)
                        list_words[i] = list_words[i-1];
                    list_words[r.position] = r.item_word;
                    list_len++;
                end
            end
            REQ_REMOVE: begin
                if (list_len == 0) begin
                    rsp.status = ST_EMPTY;
                end else if (r.position >= list_len) begin
                    rsp.status = ST_BADPOS;
                end else begin
                    rsp.result_word = list_words[r.position];
                    for (i = r.position; i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_words[list_len-1] = '0;
                    list_len--;
                end
            end
            REQ_FIND: begin
                rsp.status = ST_NOTFOUND;
                for (i = 0; i < list_len; i++) begin
                    if (!hit && list_words[i] == r.item_word) begin
                        hit = 1'b1;
                        rsp.status = ST_OK;
                        rsp.found_position = i[FPOS_W-1:0];
                    end
                end
            end
            REQ_READ: begin
                if (r.position >= list_len)
                    rsp.status = ST_BADPOS;
                else
                    rsp.result_word = list_words[r.position];
            end
            REQ_FIRST: begin
                if (list_len == 0)
                    rsp.status = ST_EMPTY;
                else
                    rsp.result_word = list_words[0];
            end
            REQ_LAST: begin
                if (list_len == 0)
                    rsp.status = ST_EMPTY;
                else
                    rsp.result_word = list_words[list_len-1];
            end
            default: begin
                rsp.status = ST_BADPOS;
            end
        endcase
        rsp.item_count = list_len[CNT_W-1:0];
        return rsp;
    endfunction

    function automatic t_req make_req(logic [TYPE_W-1:0] kind, logic [POS_W-1:0] pos,
                                      logic [WORD_WIDTH-1:0] word);
        t_req r;
        r.req_type  = kind;
        r.position  = pos;
        r.item_word = word;
        return r;
    endfunction

    // Response check and request capture; both see pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                if (rsp_expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected response: status %0d word %h fpos %0d count %0d",
                                 o_rsp.status, o_rsp.result_word, o_rsp.found_position,
                                 o_rsp.item_count);
                end else begin
                    t_rsp want;
                    want = rsp_expected_q.pop_front();
                    if (o_rsp.status !== want.status || o_rsp.result_word !== want.result_word
                        || o_rsp.found_position !== want.found_position
                        || o_rsp.item_count !== want.item_count) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("mismatch: expected st %0d word %h fpos %0d cnt %0d, got st %0d word %h fpos %0d cnt %0d",
                                     want.status, want.result_word, want.found_position,
                                     want.item_count, o_rsp.status, o_rsp.result_word,
                                     o_rsp.found_position, o_rsp.item_count);
                    end
                end
            end
            if (start && !busy)
                rsp_expected_q.push_back(apply_list_op(i_req));
        end
    end

    // Watchdog on cycles where neither a request nor a response moves
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_done)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Send one request beat, with an optional idle burst ahead of it
    task automatic send_request(t_req r);
        int gap;
        gap = 0;
        if (gaps_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 16);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
    endtask

    // Word source: small values give duplicates for find, full range toggles every bit
    function automatic logic [WORD_WIDTH-1:0] pick_word();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4)
            return WORD_WIDTH'($urandom_range(0, 7));
        else if (roll == 4)
            return '1;
        else
            return WORD_WIDTH'($urandom);
    endfunction

    function automatic logic [POS_W-1:0] pick_position(int upper);
        if ($urandom_range(0, 9) < 8)
            return POS_W'($urandom_range(0, upper < 0 ? 0 : upper));
        else
            return POS_W'($urandom_range(0, 31));
    endfunction

    // Random request, weighted toward growing or shrinking the list
    function automatic t_req random_req(bit grow);
        int                    roll;
        logic [WORD_WIDTH-1:0] word;
        roll = $urandom_range(0, 99);
        if (!grow)
            roll = (roll < 45) ? roll + 55 : roll;
        word = pick_word();
        if (roll < 45)
            return make_req(REQ_INSERT, pick_position(list_len), word);
        else if (roll < 55)
            return make_req(REQ_FIND, pick_position(list_len - 1),
                            (list_len > 0 && $urandom_range(0, 2) != 0) ?
                            list_words[$urandom_range(0, list_len - 1)] : word);
        else if (roll < 80)
            return make_req(REQ_REMOVE, pick_position(list_len - 1), word);
        else if (roll < 88)
            return make_req(REQ_READ, pick_position(list_len - 1), word);
        else if (roll < 93)
            return make_req(REQ_FIRST, POS_W'($urandom_range(0, 31)), word);
        else if (roll < 98)
            return make_req(REQ_LAST, POS_W'($urandom_range(0, 31)), word);
        else
            return make_req($urandom_range(0, 1) ? REQ_RSVD_6 : REQ_RSVD_7,
                            POS_W'($urandom_range(0, 31)), word);
    endfunction

    // Every request against an empty list, plus the undefined codes
    task automatic test_empty_list();
        send_request(make_req(REQ_REMOVE, 5'd0, '0));
        send_request(make_req(REQ_FIRST, 5'd0, '0));
        send_request(make_req(REQ_LAST, 5'd31, '1));
        send_request(make_req(REQ_FIND, 5'd0, '0));
        send_request(make_req(REQ_READ, 5'd0, '0));
        send_request(make_req(REQ_INSERT, 5'd1, 32'h1234_5678));
        send_request(make_req(REQ_RSVD_6, 5'd0, '0));
        send_request(make_req(REQ_RSVD_7, 5'd31, '1));
    endtask

    // Fill to capacity from both ends and the middle, then probe the bounds
    task automatic test_full_list();
        int                    n;
        logic [WORD_WIDTH-1:0] word;
        logic [POS_W-1:0]      pos;
        for (n = 0; n < CAPACITY; n++) begin
            case (n % 3)
                0:       pos = '0;
                1:       pos = POS_W'(n);
                default: pos = POS_W'(n / 2);
            endcase
            case (n)
                0:       word = '0;
                1:       word = '1;
                2:       word = 32'h8000_0001;
                9:       word = 32'h8000_0001;
                default: word = WORD_WIDTH'($urandom);
            endcase
            send_request(make_req(REQ_INSERT, pos, word));
        end
        send_request(make_req(REQ_INSERT, 5'd16, 32'hDEAD_BEEF));
        send_request(make_req(REQ_INSERT, 5'd17, 32'hDEAD_BEEF));
        send_request(make_req(REQ_READ, 5'd15, '0));
        send_request(make_req(REQ_READ, 5'd16, '0));
        send_request(make_req(REQ_FIND, 5'd0, 32'h8000_0001));
        send_request(make_req(REQ_FIND, 5'd0, 32'hFFFF_FFFF));
        send_request(make_req(REQ_REMOVE, 5'd16, '0));
        send_request(make_req(REQ_REMOVE, 5'd15, '0));
        send_request(make_req(REQ_REMOVE, 5'd0, '0));
        send_request(make_req(REQ_LAST, 5'd0, '0));
    endtask

    // Random mix in alternating grow and shrink phases
    task automatic test_random_mix(int n_items, bit allow_gaps);
        int n;
        for (n = 0; n < n_items; n++) begin
            if (n % 25 == 0)
                gaps_on = allow_gaps && ($urandom_range(0, 2) != 0);
            send_request(random_req((n / 40) % 2 == 0));
        end
    endtask

    initial begin
        fail_count   = 0;
        stall_cycles = 0;
        gaps_on      = 1'b1;
        list_len     = 0;
        foreach (list_words[k])
            list_words[k] = '0;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_req   = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_full_list();
        test_random_mix(320, 1'b1);
        test_random_mix(80, 1'b0);

        @(negedge i_clk);
        start <= 1'b0;
        while (rsp_expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && rsp_expected_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/plb_pkg.sv
rtl/plb_ctrl.sv
rtl/plb_dpath.sv
rtl/positional_list_buffer.sv
rtl/plb_checker.sv
test/positional_list_buffer_tb.sv
